### design/spki_pkg.sv
package spki_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int KIND_W   = 2;
  localparam int KEY_W    = 64;
  localparam int ADDR_W   = 14;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;

  // Operation codes. The unused code behaves as a lookup.
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [ADDR_W-1:0] addr;
  } entry_t;

endpackage

### design/spki_cell.sv
module spki_cell (
  input  logic            clk,
  input  logic            shift_en,
  input  spki_pkg::entry_t d,
  output spki_pkg::entry_t q
);
  import spki_pkg::*;

  entry_t entry_r;

  // One slot of the table; it takes its neighbor's entry on every shift.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      entry_r <= d;
    end
  end

  assign q = entry_r;

endmodule

### design/spki_head.sv
module spki_head #(
  parameter int CAPACITY = spki_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [spki_pkg::KIND_W-1:0]   in_kind,
  input  logic [spki_pkg::KEY_W-1:0]    in_key,
  input  logic [spki_pkg::ADDR_W-1:0]   in_record_address,
  input  spki_pkg::entry_t              head_q,
  input  spki_pkg::entry_t              next_q,
  output spki_pkg::entry_t              tail_d,
  output logic                          shift_en,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [spki_pkg::STATUS_W-1:0] out_status,
  output logic [spki_pkg::POS_W-1:0]    out_position,
  output logic [spki_pkg::ADDR_W-1:0]   out_found_address,
  output logic [spki_pkg::COUNT_W-1:0]  out_entry_count
);
  import spki_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} state_t;

  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     step_r, step_nxt;
  logic [KIND_W-1:0]    kind_r, kind_nxt;
  logic [KEY_W-1:0]     key_r, key_nxt;
  logic [ADDR_W-1:0]    rec_addr_r, rec_addr_nxt;
  logic [CNT_W-1:0]     used_r, used_nxt;
  logic                 done_r, done_nxt;
  logic                 shift_r, shift_nxt;
  entry_t               hold_r, hold_nxt;
  logic [STATUS_W-1:0]  status_r, status_nxt;
  logic [IDX_W-1:0]     pos_r, pos_nxt;
  logic [ADDR_W-1:0]    found_r, found_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [POS_W-1:0]     out_pos_r, out_pos_nxt;
  logic [ADDR_W-1:0]    out_found_r, out_found_nxt;
  logic [COUNT_W-1:0]   out_count_r, out_count_nxt;

  logic [CNT_W-1:0] step_ext;
  logic [CNT_W-1:0] step_inc;
  logic             in_use;
  logic             at_used;
  logic             next_in_use;
  logic             key_eq;
  logic             key_gt;

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    kind_nxt       = kind_r;
    key_nxt        = key_r;
    rec_addr_nxt   = rec_addr_r;
    used_nxt       = used_r;
    done_nxt       = done_r;
    shift_nxt      = shift_r;
    hold_nxt       = hold_r;
    status_nxt     = status_r;
    pos_nxt        = pos_r;
    found_nxt      = found_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;

    tail_d   = head_q;
    shift_en = (state_r == S_SCAN);
    in_ready = (state_r == S_IDLE);

    step_ext    = CNT_W'(step_r);
    step_inc    = step_ext + CNT_W'(1);
    in_use      = step_ext < used_r;
    at_used     = step_ext == used_r;
    next_in_use = step_inc < used_r;
    key_eq      = in_use && (head_q.key == key_r);
    key_gt      = in_use && (head_q.key > key_r);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt     = in_kind;
          key_nxt      = in_key;
          rec_addr_nxt = in_record_address;
          step_nxt     = '0;
          done_nxt     = 1'b0;
          shift_nxt    = 1'b0;
          pos_nxt      = '0;
          found_nxt    = '0;
          status_nxt   = (in_kind == KIND_INSERT) ? ST_FULL : ST_MISSING;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        case (kind_r)
          KIND_INSERT: begin
            if (!done_r) begin
              if (key_eq) begin
                done_nxt   = 1'b1;
                status_nxt = ST_DUP;
              end else if ((used_r != FULL_CNT) && (key_gt || at_used)) begin
                tail_d.key  = key_r;
                tail_d.addr = rec_addr_r;
                hold_nxt    = head_q;
                done_nxt    = 1'b1;
                shift_nxt   = 1'b1;
                status_nxt  = ST_OK;
                pos_nxt     = step_r;
              end
            end else if (shift_r && (step_ext <= used_r)) begin
              tail_d   = hold_r;
              hold_nxt = head_q;
            end
          end
          KIND_DELETE: begin
            if (!done_r && key_eq) begin
              done_nxt   = 1'b1;
              shift_nxt  = 1'b1;
              status_nxt = ST_OK;
              pos_nxt    = step_r;
              found_nxt  = head_q.addr;
              if (next_in_use) begin
                tail_d = next_q;
              end
            end else if (shift_r && next_in_use) begin
              tail_d = next_q;
            end
          end
          default: begin
            if (!done_r && key_eq) begin
              done_nxt   = 1'b1;
              status_nxt = ST_OK;
              pos_nxt    = step_r;
              found_nxt  = head_q.addr;
            end
          end
        endcase

        step_nxt = step_r + IDX_W'(1);
        if (step_r == LAST_IDX) begin
          state_nxt = S_FIN;
          if (shift_nxt) begin
            if (kind_r == KIND_INSERT) begin
              used_nxt = used_r + CNT_W'(1);
            end else begin
              used_nxt = used_r - CNT_W'(1);
            end
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_pos_nxt    = POS_W'(pos_r);
          out_found_nxt  = found_r;
          out_count_nxt  = COUNT_W'(used_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      done_r      <= 1'b0;
      shift_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      done_r      <= done_nxt;
      shift_r     <= shift_nxt;
    end
    step_r       <= step_nxt;
    kind_r       <= kind_nxt;
    key_r        <= key_nxt;
    rec_addr_r   <= rec_addr_nxt;
    hold_r       <= hold_nxt;
    status_r     <= status_nxt;
    pos_r        <= pos_nxt;
    found_r      <= found_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_position      = out_pos_r;
  assign out_found_address = out_found_r;
  assign out_entry_count   = out_count_r;

endmodule

### design/sorted_primary_key_index_top.sv
// Sorted primary-key index: a table of (key, record address) pairs kept in
// ascending unsigned key order. Each input word on the in_ channel carries one
// operation (insert, lookup or delete, with the unused code acting as lookup),
// and each produces exactly one result word on the out_ channel with a status,
// the sorted position involved, the stored address and the entry count.
// The table lives in a ring of CAPACITY cells. An operation rotates the whole
// ring once, one cell per cycle, past a head unit that compares each entry
// with the key and rewrites it on the way back in, so insert and delete open
// or close the gap during the same pass. The result register is loaded from
// the finishing state once the pass ends, and the input reopens as it is
// loaded, so a new word is accepted only after the previous one has finished
// its rotation and produced its result; that single rotation sets the throughput.
// The result register lets the next word enter while a result still waits;
// if the receiver stalls longer, the finished operation holds in the head
// unit and in_ready stays low until the result register frees up.
// Reset (rst_n low at a clock edge) empties the table and drops any pending
// result; the cell contents are not cleared, since only slots below the entry
// count are ever examined.
module sorted_primary_key_index_top #(
  parameter int CAPACITY = spki_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [spki_pkg::KIND_W-1:0]   in_kind,
  input  logic [spki_pkg::KEY_W-1:0]    in_key,
  input  logic [spki_pkg::ADDR_W-1:0]   in_record_address,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [spki_pkg::STATUS_W-1:0] out_status,
  output logic [spki_pkg::POS_W-1:0]    out_position,
  output logic [spki_pkg::ADDR_W-1:0]   out_found_address,
  output logic [spki_pkg::COUNT_W-1:0]  out_entry_count
);
  import spki_pkg::*;

  // Cell i holds table slot i between operations; during a pass each cell
  // takes its upper neighbor's entry and the top cell takes the head's output.
  entry_t chain_q [CAPACITY];
  entry_t tail_d;
  logic   shift_en;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == CAPACITY - 1) begin : g_top
      spki_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .d        (tail_d),
        .q        (chain_q[g])
      );
    end else begin : g_mid
      spki_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .d        (chain_q[g+1]),
        .q        (chain_q[g])
      );
    end
  end

  // The head sees slot j in cell 0 and slot j + 1 in cell 1 at pass step j.
  spki_head #(
    .CAPACITY (CAPACITY)
  ) u_head (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_key            (in_key),
    .in_record_address (in_record_address),
    .head_q            (chain_q[0]),
    .next_q            (chain_q[1]),
    .tail_d            (tail_d),
    .shift_en          (shift_en),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_position      (out_position),
    .out_found_address (out_found_address),
    .out_entry_count   (out_entry_count)
  );

endmodule

### design/spki_checker.sv
module spki_props (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [spki_pkg::STATUS_W-1:0] out_status,
  input logic [spki_pkg::POS_W-1:0]    out_position,
  input logic [spki_pkg::ADDR_W-1:0]   out_found_address,
  input logic [spki_pkg::COUNT_W-1:0]  out_entry_count
);
  import spki_pkg::*;

  // A stalled result word keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_position) && $stable(out_found_address) && $stable(out_entry_count))
    else $error("result word changed while stalled");

  // One operation at a time: the cycle after an accept the input is closed.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an operation is in flight");

  // A failed operation reports neither a position nor an address.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_position == '0) &&
      (out_found_address == '0))
    else $error("failed operation carries position or address");

  // Reset leaves no result pending and the input open.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind sorted_primary_key_index_top spki_props u_spki_props (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_status        (out_status),
  .out_position      (out_position),
  .out_found_address (out_found_address),
  .out_entry_count   (out_entry_count)
);
